// ===== sv/pcs_pkg.sv =====
// pcs_pkg: shared types, codes and reset constants of the pressure chamber sequencer
// no dependencies
`default_nettype none

package pcs_pkg;

    localparam int TIME_WIDTH = 32;

    localparam logic [15:0] START_ALT_RST = 16'd1000;
    localparam logic [15:0] ALT_STEP_RST  = 16'd1000;
    localparam logic [16:0] PRS_UPPER_RST = 17'd90000;
    localparam logic [16:0] PRS_LOWER_RST = 17'd85000;
    localparam logic [31:0] PUMP_TMO_RST  = 32'd60000;
    localparam logic [31:0] DRAIN_TMO_RST = 32'd10000;
    localparam logic [15:0] MAX_ALT_RST   = 16'd12000;

    localparam logic [15:0] MARK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PUMP  = 2'd1,
        MODE_DRAIN = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_START_ALT = 3'd0,
        CFG_ALT_STEP  = 3'd1,
        CFG_PRS_UPPER = 3'd2,
        CFG_PRS_LOWER = 3'd3,
        CFG_PUMP_TMO  = 3'd4,
        CFG_DRAIN_TMO = 3'd5,
        CFG_MAX_ALT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] start_altitude_m;
        logic [15:0] altitude_step_m;
        logic [16:0] pressure_upper_pa;
        logic [16:0] pressure_lower_pa;
        logic [31:0] pump_timeout_ms;
        logic [31:0] drain_timeout_ms;
        logic [15:0] max_pump_altitude_m;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } t_mark_load;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               altitude_valid;
        logic signed [16:0] altitude_m;
        logic               pressure_valid;
        logic [16:0]        pressure_pa;
    } t_poll;

    typedef struct packed {
        logic [1:0] mode;
        logic       pump_drive;
        logic       valve_open;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/pcs_poll_if.sv =====
// pcs_poll_if: request channel carrying one poll
// no dependencies
`default_nettype none

interface pcs_poll_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               altitude_valid;
    logic signed [16:0] altitude_m;
    logic               pressure_valid;
    logic [16:0]        pressure_pa;

    modport source (
        output valid, now_ms, altitude_valid, altitude_m, pressure_valid, pressure_pa,
        input  ready
    );
    modport sink (
        input  valid, now_ms, altitude_valid, altitude_m, pressure_valid, pressure_pa,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pcs_status_if.sv =====
// pcs_status_if: result channel carrying mode and actuator levels
// no dependencies
`default_nettype none

interface pcs_status_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       pump_drive;
    logic       valve_open;

    modport source (
        output valid, mode, pump_drive, valve_open,
        input  ready
    );
    modport sink (
        input  valid, mode, pump_drive, valve_open,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pressure_chamber_sequencer.sv =====
// pressure_chamber_sequencer: top level, poll register, result register and handshakes
// depends on pcs_pkg, pcs_poll_if, pcs_status_if, pcs_cfg, pcs_core
// a poll passes the poll register and then the status register to its status request
// throughput: one poll per cycle unless the sink stalls; the status register decouples
// a stalled sink by one entry; sequencing is combinational between the two registers
// reset: synchronous active low; idle mode, actuators off, registers at defaults
`default_nettype none

module pressure_chamber_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pcs_poll_if.sink         i_poll,
    pcs_status_if.source     o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    pcs_pkg::t_cfg       cfg;
    pcs_pkg::t_mark_load mark_load;
    pcs_pkg::t_res       res;

    logic                r_in_valid;
    pcs_pkg::t_poll      r_in;
    logic                r_out_valid;
    pcs_pkg::t_res       r_out;
    logic                step;
    logic                in_ready;

    assign step     = r_in_valid && (!r_out_valid || o_status.ready);
    assign in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_poll.valid) begin
            r_in.now_ms         <= i_poll.now_ms;
            r_in.altitude_valid <= i_poll.altitude_valid;
            r_in.altitude_m     <= i_poll.altitude_m;
            r_in.pressure_valid <= i_poll.pressure_valid;
            r_in.pressure_pa    <= i_poll.pressure_pa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_status.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    pcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_mark_load (mark_load)
    );

    pcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mark_load (mark_load),
        .i_step      (step),
        .i_poll      (r_in),
        .o_res       (res)
    );

    assign i_poll.ready        = in_ready;
    assign o_status.valid      = r_out_valid;
    assign o_status.mode       = r_out.mode;
    assign o_status.pump_drive = r_out.pump_drive;
    assign o_status.valve_open = r_out.valve_open;

endmodule

`default_nettype wire

// ===== sv/pcs_cfg.sv =====
// pcs_cfg: configuration register file with write port
// depends on pcs_pkg
`default_nettype none

module pcs_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_idx,
    input  wire logic [31:0]     i_cfg_data,
    output pcs_pkg::t_cfg        o_cfg,
    output pcs_pkg::t_mark_load  o_mark_load
);

    pcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_altitude_m    <= pcs_pkg::START_ALT_RST;
            r_cfg.altitude_step_m     <= pcs_pkg::ALT_STEP_RST;
            r_cfg.pressure_upper_pa   <= pcs_pkg::PRS_UPPER_RST;
            r_cfg.pressure_lower_pa   <= pcs_pkg::PRS_LOWER_RST;
            r_cfg.pump_timeout_ms     <= pcs_pkg::PUMP_TMO_RST;
            r_cfg.drain_timeout_ms    <= pcs_pkg::DRAIN_TMO_RST;
            r_cfg.max_pump_altitude_m <= pcs_pkg::MAX_ALT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcs_pkg::CFG_START_ALT: r_cfg.start_altitude_m    <= i_cfg_data[15:0];
                pcs_pkg::CFG_ALT_STEP:  r_cfg.altitude_step_m     <= i_cfg_data[15:0];
                pcs_pkg::CFG_PRS_UPPER: r_cfg.pressure_upper_pa   <= i_cfg_data[16:0];
                pcs_pkg::CFG_PRS_LOWER: r_cfg.pressure_lower_pa   <= i_cfg_data[16:0];
                pcs_pkg::CFG_PUMP_TMO:  r_cfg.pump_timeout_ms     <= i_cfg_data;
                pcs_pkg::CFG_DRAIN_TMO: r_cfg.drain_timeout_ms    <= i_cfg_data;
                pcs_pkg::CFG_MAX_ALT:   r_cfg.max_pump_altitude_m <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg             = r_cfg;
    assign o_mark_load.load  = i_cfg_we && (i_cfg_idx == pcs_pkg::CFG_START_ALT);
    assign o_mark_load.value = i_cfg_data[15:0];

endmodule

`default_nettype wire

// ===== sv/pcs_core.sv =====
// pcs_core: sequencer state and the per-poll mode, hysteresis and mark logic
// depends on pcs_pkg
`default_nettype none

module pcs_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pcs_pkg::t_cfg       i_cfg,
    input  wire pcs_pkg::t_mark_load i_mark_load,
    input  wire logic                i_step,
    input  wire pcs_pkg::t_poll      i_poll,
    output pcs_pkg::t_res            o_res
);

    pcs_pkg::t_mode                  r_mode, n_mode;
    logic                            r_pump, n_pump;
    logic                            r_valve, n_valve;
    logic signed [16:0]              r_last_alt, n_last_alt;
    logic [16:0]                     r_last_prs, n_last_prs;
    logic                            r_pend, n_pend;
    logic [15:0]                     r_mark, n_mark;
    logic [pcs_pkg::TIME_WIDTH-1:0]  r_pump_start, n_pump_start;
    logic [pcs_pkg::TIME_WIDTH-1:0]  r_drain_start, n_drain_start;

    logic [pcs_pkg::TIME_WIDTH-1:0]  now;
    logic [pcs_pkg::TIME_WIDTH-1:0]  pump_elapsed;
    logic [pcs_pkg::TIME_WIDTH-1:0]  drain_elapsed;
    logic [16:0]                     mark_sum;
    logic                            mark_hit;

    assign now           = pcs_pkg::TIME_WIDTH'(i_poll.now_ms);
    assign pump_elapsed  = now - r_pump_start;
    assign drain_elapsed = now - r_drain_start;
    assign mark_sum      = {1'b0, r_mark} + {1'b0, i_cfg.altitude_step_m};

    always_comb begin
        n_last_alt    = i_poll.altitude_valid ? i_poll.altitude_m : r_last_alt;
        n_last_prs    = i_poll.pressure_valid ? i_poll.pressure_pa : r_last_prs;
        n_pend        = i_poll.pressure_valid | r_pend;
        n_mode        = r_mode;
        n_pump        = r_pump;
        n_valve       = r_valve;
        n_pump_start  = r_pump_start;
        n_drain_start = r_drain_start;
        n_mark        = r_mark;

        case (r_mode)
            pcs_pkg::MODE_PUMP: begin
                if (pump_elapsed > i_cfg.pump_timeout_ms) begin
                    n_pump  = 1'b0;
                    n_valve = 1'b0;
                    n_mode  = pcs_pkg::MODE_IDLE;
                end else if (n_pend) begin
                    n_pend = 1'b0;
                    if (n_last_prs >= i_cfg.pressure_upper_pa) begin
                        n_pump = 1'b0;
                    end else if (n_last_prs <= i_cfg.pressure_lower_pa) begin
                        n_pump = 1'b1;
                    end
                end
            end
            pcs_pkg::MODE_DRAIN: begin
                if (drain_elapsed > i_cfg.drain_timeout_ms) begin
                    if (n_last_alt <= $signed({1'b0, i_cfg.max_pump_altitude_m})) begin
                        n_valve      = 1'b0;
                        n_pump       = 1'b1;
                        n_pump_start = now;
                        n_mode       = pcs_pkg::MODE_PUMP;
                    end else begin
                        n_pump  = 1'b0;
                        n_valve = 1'b0;
                        n_mode  = pcs_pkg::MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase

        mark_hit = i_poll.altitude_valid && (n_last_alt > $signed({1'b0, r_mark}));
        if (mark_hit) begin
            if (n_mode == pcs_pkg::MODE_IDLE) begin
                n_valve       = 1'b1;
                n_pump        = 1'b1;
                n_drain_start = now;
                n_mode        = pcs_pkg::MODE_DRAIN;
            end
            n_mark = mark_sum[16] ? pcs_pkg::MARK_MAX : mark_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pcs_pkg::MODE_IDLE;
            r_pump        <= 1'b0;
            r_valve       <= 1'b0;
            r_last_alt    <= '0;
            r_last_prs    <= '0;
            r_pend        <= 1'b0;
            r_mark        <= pcs_pkg::START_ALT_RST;
            r_pump_start  <= '0;
            r_drain_start <= '0;
        end else if (i_mark_load.load) begin
            r_mark <= i_mark_load.value;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_pump        <= n_pump;
            r_valve       <= n_valve;
            r_last_alt    <= n_last_alt;
            r_last_prs    <= n_last_prs;
            r_pend        <= n_pend;
            r_mark        <= n_mark;
            r_pump_start  <= n_pump_start;
            r_drain_start <= n_drain_start;
        end
    end

    assign o_res.mode       = n_mode;
    assign o_res.pump_drive = n_pump;
    assign o_res.valve_open = n_valve;

endmodule

`default_nettype wire

// ===== tb/pcs_status_checker.sv =====
`timescale 1ns / 1ps
// pcs_status_checker: follows polls, register writes and status requests of the
// pressure chamber sequencer, predicts every status and compares it field by field
// depends on pcs_pkg
module pcs_status_checker
    import pcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_poll_valid,
    input  wire logic        i_poll_ready,
    input  t_poll            i_poll,
    input  wire logic        i_status_valid,
    input  wire logic        i_status_ready,
    input  t_res             i_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    t_cfg               regs;
    t_mode              cur_mode;
    logic               pump_lvl;
    logic               valve_lvl;
    logic signed [16:0] alt_last;
    logic [16:0]        prs_last;
    logic               prs_fresh;
    logic [15:0]        alt_mark;
    logic [31:0]        pump_t0;
    logic [31:0]        drain_t0;

    t_res status_due[$];
    t_res due;
    int   mism_cnt;
    int   done_cnt;

    function automatic t_res step_sequencer(t_poll p);
        t_res        r;
        int          alt_now;
        int          nm;
        logic [31:0] dt;
        if (p.altitude_valid)
            alt_last = p.altitude_m;
        if (p.pressure_valid) begin
            prs_last  = p.pressure_pa;
            prs_fresh = 1'b1;
        end
        alt_now = alt_last;
        case (cur_mode)
            MODE_PUMP: begin
                dt = p.now_ms - pump_t0;
                if (dt > regs.pump_timeout_ms) begin
                    pump_lvl  = 1'b0;
                    valve_lvl = 1'b0;
                    cur_mode  = MODE_IDLE;
                end else if (prs_fresh) begin
                    prs_fresh = 1'b0;
                    // upper threshold wins when the two are crossed
                    if (prs_last >= regs.pressure_upper_pa)
                        pump_lvl = 1'b0;
                    else if (prs_last <= regs.pressure_lower_pa)
                        pump_lvl = 1'b1;
                end
            end
            MODE_DRAIN: begin
                dt = p.now_ms - drain_t0;
                if (dt > regs.drain_timeout_ms) begin
                    if (alt_now <= int'(regs.max_pump_altitude_m)) begin
                        valve_lvl = 1'b0;
                        pump_lvl  = 1'b1;
                        pump_t0   = p.now_ms;
                        cur_mode  = MODE_PUMP;
                    end else begin
                        pump_lvl  = 1'b0;
                        valve_lvl = 1'b0;
                        cur_mode  = MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase
        if (p.altitude_valid && alt_now > int'(alt_mark)) begin
            if (cur_mode == MODE_IDLE) begin
                valve_lvl = 1'b1;
                pump_lvl  = 1'b1;
                drain_t0  = p.now_ms;
                cur_mode  = MODE_DRAIN;
            end
            nm = int'(alt_mark) + int'(regs.altitude_step_m);
            alt_mark = (nm > int'(MARK_MAX)) ? MARK_MAX : nm[15:0];
        end
        r.mode       = cur_mode;
        r.pump_drive = pump_lvl;
        r.valve_open = valve_lvl;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '{START_ALT_RST, ALT_STEP_RST, PRS_UPPER_RST, PRS_LOWER_RST,
                     PUMP_TMO_RST, DRAIN_TMO_RST, MAX_ALT_RST};
            cur_mode  = MODE_IDLE;
            pump_lvl  = 1'b0;
            valve_lvl = 1'b0;
            alt_last  = '0;
            prs_last  = '0;
            prs_fresh = 1'b0;
            alt_mark  = START_ALT_RST;
            pump_t0   = '0;
            drain_t0  = '0;
            status_due.delete();
            mism_cnt  = 0;
            done_cnt  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_ALT: begin
                        regs.start_altitude_m = i_cfg_data[15:0];
                        alt_mark = i_cfg_data[15:0];
                    end
                    CFG_ALT_STEP:  regs.altitude_step_m     = i_cfg_data[15:0];
                    CFG_PRS_UPPER: regs.pressure_upper_pa   = i_cfg_data[16:0];
                    CFG_PRS_LOWER: regs.pressure_lower_pa   = i_cfg_data[16:0];
                    CFG_PUMP_TMO:  regs.pump_timeout_ms     = i_cfg_data;
                    CFG_DRAIN_TMO: regs.drain_timeout_ms    = i_cfg_data;
                    CFG_MAX_ALT:   regs.max_pump_altitude_m = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_status_valid && i_status_ready) begin
                if (status_due.size() == 0) begin
                    $error("status request with no poll outstanding");
                    mism_cnt++;
                end else begin
                    due = status_due.pop_front();
                    if (i_status.mode !== due.mode) begin
                        $error("mode: expected %0d, got %0d", due.mode, i_status.mode);
                        mism_cnt++;
                    end
                    if (i_status.pump_drive !== due.pump_drive) begin
                        $error("pump_drive: expected %0d, got %0d",
                               due.pump_drive, i_status.pump_drive);
                        mism_cnt++;
                    end
                    if (i_status.valve_open !== due.valve_open) begin
                        $error("valve_open: expected %0d, got %0d",
                               due.valve_open, i_status.valve_open);
                        mism_cnt++;
                    end
                    done_cnt++;
                end
            end
            if (i_poll_valid && i_poll_ready)
                status_due.push_back(step_sequencer(i_poll));
        end
        o_fail_count <= mism_cnt;
        o_pending    <= status_due.size();
        o_checked    <= done_cnt;
    end

endmodule

// ===== tb/pressure_chamber_sequencer_tb.sv =====
`timescale 1ns / 1ps
// pressure_chamber_sequencer_tb: clock, reset, poll and register stimulus, status
// back-pressure and the verdict; depends on pcs_pkg, pcs_poll_if, pcs_status_if,
// pcs_status_checker and pressure_chamber_sequencer
module pressure_chamber_sequencer_tb;
    import pcs_pkg::*;

    localparam int unsigned LIMIT_NS   = 2_000_000;
    localparam logic [2:0]  CFG_UNUSED = 3'd7;
    localparam int          PRS_MAX    = 131071;
    localparam int          ALT_MIN    = -2000;
    localparam int          ALT_MAX    = 60000;
    localparam int          HOLD_LEN   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    pcs_poll_if   poll_ch();
    pcs_status_if status_ch();

    int          fail_count;
    int          pending;
    int          checked;
    t_cfg        cur_cfg;
    logic [31:0] now_track;
    int          alt_track;
    int          polls_sent;
    int          settings;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done;
    int          hold_left;
    int          stall_left;

    pressure_chamber_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_poll     (poll_ch),
        .o_status   (status_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pcs_status_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_poll_valid   (poll_ch.valid),
        .i_poll_ready   (poll_ch.ready),
        .i_poll         ({poll_ch.now_ms, poll_ch.altitude_valid, poll_ch.altitude_m,
                          poll_ch.pressure_valid, poll_ch.pressure_pa}),
        .i_status_valid (status_ch.valid),
        .i_status_ready (status_ch.ready),
        .i_status       ({status_ch.mode, status_ch.pump_drive, status_ch.valve_open}),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // status back-pressure: random stall bursts and one long hold
    initial begin
        status_ch.ready = 1'b0;
        hold_done  = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                status_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                status_ch.ready = 1'b0;
            end else if (stall_left > 0) begin
                status_ch.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                status_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 16);
            end else begin
                status_ch.ready = 1'b1;
            end
        end
    end

    task automatic send_poll(input logic [31:0] now, input bit av, input int alt,
                             input bit pv, input int prs);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            poll_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        poll_ch.now_ms         = now;
        poll_ch.altitude_valid = av;
        poll_ch.altitude_m     = alt[16:0];
        poll_ch.pressure_valid = pv;
        poll_ch.pressure_pa    = prs[16:0];
        poll_ch.valid          = 1'b1;
        do @(posedge i_clk); while (!poll_ch.ready);
        polls_sent++;
    endtask

    // drain every outstanding status, then let the pipeline settle
    task automatic wait_quiet();
        @(negedge i_clk);
        poll_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = d;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        cur_cfg = c;
        write_reg(CFG_START_ALT, 32'(c.start_altitude_m));
        write_reg(CFG_ALT_STEP,  32'(c.altitude_step_m));
        write_reg(CFG_PRS_UPPER, 32'(c.pressure_upper_pa));
        write_reg(CFG_PRS_LOWER, 32'(c.pressure_lower_pa));
        write_reg(CFG_PUMP_TMO,  c.pump_timeout_ms);
        write_reg(CFG_DRAIN_TMO, c.drain_timeout_ms);
        write_reg(CFG_MAX_ALT,   32'(c.max_pump_altitude_m));
        settings++;
    endtask

    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   lo;
        c.start_altitude_m = 16'($urandom_range(0, 20000));
        c.altitude_step_m  = ($urandom_range(0, 7) == 0) ? 16'd60000
                                                         : 16'($urandom_range(1, 4000));
        lo = $urandom_range(0, 120000);
        case ($urandom_range(0, 3))
            0: begin
                c.pressure_upper_pa = 17'($urandom_range(0, PRS_MAX));
                c.pressure_lower_pa = 17'($urandom_range(0, PRS_MAX));
            end
            1: begin
                // thresholds crossed
                c.pressure_upper_pa = 17'(lo);
                c.pressure_lower_pa = 17'(lo + int'($urandom_range(0, 11071)));
            end
            default: begin
                c.pressure_lower_pa = 17'(lo);
                c.pressure_upper_pa = 17'(lo + int'($urandom_range(0, 11071)));
            end
        endcase
        c.pump_timeout_ms     = $urandom_range(0, 3000);
        c.drain_timeout_ms    = $urandom_range(0, 2000);
        c.max_pump_altitude_m = 16'($urandom_range(0, 60000));
        return c;
    endfunction

    // climbing altitude with random content, time steps around the timeouts
    task automatic random_polls(input int n);
        logic [31:0] dt;
        int          alt;
        int          prs;
        bit          av;
        bit          pv;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: dt = $urandom_range(0, 40);
                4, 5:       dt = cur_cfg.drain_timeout_ms + $urandom_range(0, 4) - 2;
                6, 7:       dt = cur_cfg.pump_timeout_ms + $urandom_range(0, 4) - 2;
                8:          dt = $urandom_range(0, cur_cfg.drain_timeout_ms / 3 + 1);
                default:    dt = $urandom();
            endcase
            now_track += dt;
            if ($urandom_range(0, 9) == 0)
                alt_track = int'($urandom_range(0, ALT_MAX - ALT_MIN)) + ALT_MIN;
            else
                alt_track += int'($urandom_range(0, int'(cur_cfg.altitude_step_m) * 3 / 2));
            if (alt_track > ALT_MAX)
                alt_track = int'($urandom_range(0, 3000)) + ALT_MIN;
            av  = ($urandom_range(0, 9) < 7);
            alt = av ? alt_track : int'($urandom_range(0, ALT_MAX - ALT_MIN)) + ALT_MIN;
            pv  = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: prs = int'(cur_cfg.pressure_lower_pa) + int'($urandom_range(0, 6)) - 3;
                4, 5:       prs = int'(cur_cfg.pressure_upper_pa) + int'($urandom_range(0, 6)) - 3;
                6:          prs = 0;
                7:          prs = PRS_MAX;
                default:    prs = $urandom_range(0, PRS_MAX);
            endcase
            if (prs < 0)
                prs = 0;
            if (prs > PRS_MAX)
                prs = PRS_MAX;
            send_poll(now_track, av, alt, pv, prs);
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_START_ALT;
        cfg_data = '0;
        poll_ch.valid          = 1'b0;
        poll_ch.now_ms         = '0;
        poll_ch.altitude_valid = 1'b0;
        poll_ch.altitude_m     = '0;
        poll_ch.pressure_valid = 1'b0;
        poll_ch.pressure_pa    = '0;
        cur_cfg = '{START_ALT_RST, ALT_STEP_RST, PRS_UPPER_RST, PRS_LOWER_RST,
                    PUMP_TMO_RST, DRAIN_TMO_RST, MAX_ALT_RST};
        polls_sent = 0;
        settings   = 1;
        alt_track  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: mark 1000, drain 10000 ms, pump 60000 ms, max altitude 12000
        send_poll(32'd100,   1'b0, 0,      1'b0, 0);
        send_poll(32'd110,   1'b0, 60000,  1'b1, PRS_MAX);   // stale pressure while idle
        send_poll(32'd120,   1'b1, 1000,   1'b0, 0);         // at the mark, no start
        send_poll(32'd130,   1'b1, 1001,   1'b0, 0);         // past the mark, drain
        send_poll(32'd10130, 1'b1, ALT_MIN, 1'b0, 0);        // elapsed equals timeout
        send_poll(32'd10131, 1'b0, 0,      1'b0, 0);         // drain over, pump
        send_poll(32'd10140, 1'b0, 0,      1'b0, 0);         // pending pressure used
        send_poll(32'd10150, 1'b0, 0,      1'b1, 0);
        send_poll(32'd10160, 1'b0, 0,      1'b1, 87000);     // between thresholds
        send_poll(32'd10170, 1'b0, 0,      1'b1, 90000);
        send_poll(32'd10180, 1'b0, 0,      1'b1, 85000);
        send_poll(32'd10190, 1'b1, 2500,   1'b0, 0);         // mark moves while pumping
        send_poll(32'd70131, 1'b0, 0,      1'b1, 0);
        send_poll(32'd70132, 1'b0, 0,      1'b0, 0);         // pump timeout
        send_poll(32'd70140, 1'b1, ALT_MAX, 1'b0, 0);
        send_poll(32'd80141, 1'b0, 0,      1'b0, 0);         // too high to pump
        send_poll(32'hFFFF_FFF0, 1'b1, 4001, 1'b0, 0);
        send_poll(32'h0000_2700, 1'b0, 0,  1'b0, 0);         // wrapped, not yet over
        send_poll(32'h0000_2701, 1'b0, 0,  1'b0, 0);
        send_poll(32'h0000_2710, 1'b1, 12000, 1'b1, PRS_MAX);
        send_poll(32'hFFFF_FFFF, 1'b1, 12000, 1'b0, 0);      // timeout and restart together
        send_poll(32'h0000_2710, 1'b0, 0,  1'b0, 0);         // altitude equal to maximum
        now_track = 32'h0000_2710;
        random_polls(120);

        wait_quiet();
        apply_cfg('{16'd0, 16'd1, 17'd131071, 17'd0, 32'd0, 32'd0, 16'd0});
        random_polls(100);

        wait_quiet();
        apply_cfg('{16'd59000, 16'd60000, 17'd0, 17'd131071,
                    32'hFFFF_FFFF, 32'd0, 16'd60000});
        write_reg(CFG_UNUSED, $urandom());
        random_polls(60);

        wait_quiet();
        apply_cfg('{16'd1000, 16'd500, 17'd100000, 17'd20000,
                    32'd100, 32'hFFFF_FFFF, 16'd30000});
        random_polls(40);

        for (int k = 0; k < 5; k++) begin
            wait_quiet();
            apply_cfg(rand_cfg());
            if (k == 1) begin
                hold_req = 1'b1;
                random_polls(40);
                wait_quiet();
            end
            if (k == 4)
                idle_on = 1'b0;
            random_polls(130);
        end

        wait_quiet();
        repeat (8) @(negedge i_clk);
        $display("run covered %0d polls under %0d register settings, %0d status results compared",
                 polls_sent, settings, checked);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
